>>> rtl/sidd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sidd_pkg
// Shared constants, types and helper functions for the signed integer to
// decimal digit converter.
// ----------------------------------------------------------------------------
package sidd_pkg;

  localparam int VALUE_W     = 32;                    // input integer width
  localparam int DIGIT_W     = 4;                     // one BCD digit
  localparam int DIGITS_MAX  = 10;                    // digits of 2^31
  localparam int BCD_W       = DIGITS_MAX * DIGIT_W;  // packed BCD width
  localparam int DD_W        = BCD_W + VALUE_W;       // double dabble state
  localparam int DD_STAGES   = 4;                     // pipeline stages
  localparam int STAGE_STEPS = VALUE_W / DD_STAGES;   // shift steps per stage
  localparam int POS_W       = 4;                     // digit position / count

  typedef logic [VALUE_W-1:0] mag_t;
  typedef logic [BCD_W-1:0]   bcd_t;
  typedef logic [DD_W-1:0]    dd_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [DIGIT_W-1:0] digit_t;

  // A group of double dabble steps: add 3 to every digit >= 5, then shift.
  function automatic dd_t dd_steps(input dd_t state);
    dd_t    s;
    digit_t d;
    s = state;
    for (int step = 0; step < STAGE_STEPS; step++) begin
      for (int k = 0; k < DIGITS_MAX; k++) begin
        d = s[VALUE_W + k*DIGIT_W +: DIGIT_W];
        if (d >= digit_t'(5)) begin
          s[VALUE_W + k*DIGIT_W +: DIGIT_W] = d + digit_t'(3);
        end
      end
      s = {s[DD_W-2:0], 1'b0};
    end
    return s;
  endfunction

  // Number of significant digits, at least one.
  function automatic pos_t digit_count_of(input bcd_t bcd);
    pos_t n;
    n = pos_t'(1);
    for (int k = 1; k < DIGITS_MAX; k++) begin
      if (bcd[k*DIGIT_W +: DIGIT_W] != '0) begin
        n = pos_t'(k + 1);
      end
    end
    return n;
  endfunction

  // Pick one digit of the packed BCD word.
  function automatic digit_t digit_at(input bcd_t bcd, input pos_t pos);
    digit_t d;
    d = '0;
    for (int k = 0; k < DIGITS_MAX; k++) begin
      if (pos == pos_t'(k)) begin
        d = bcd[k*DIGIT_W +: DIGIT_W];
      end
    end
    return d;
  endfunction

endpackage
`default_nettype wire

>>> rtl/sidd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sidd_operand_if / sidd_digit_if
// Valid/ready channels for the integer requests and the digit results.
// ----------------------------------------------------------------------------
interface sidd_operand_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sidd_digit_if;
  logic       valid;
  logic       ready;
  logic [3:0] digit;
  logic [3:0] digit_count;
  logic       last_digit;

  modport source (output valid, output digit, output digit_count,
                  output last_digit, input ready);
  modport sink   (input valid, input digit, input digit_count,
                  input last_digit, output ready);
endinterface
`default_nettype wire

>>> rtl/signed_int_to_decimal_digits_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// The first digit of a request leaves after the magnitude register, four
//   double dabble stages, the digit count stage and the digit serializer.
// Output: one digit per cycle while digits.ready is high; an integer of N
//   digits (1 to 10) gives N results from the digit serializer at the output.
// Reset (rst, synchronous) empties every pipeline stage and the serializer.
// ----------------------------------------------------------------------------
// signed_int_to_decimal_digits_unit
// Converts the magnitude of a signed 32-bit integer to decimal digits,
// most significant first, one result per digit, with no leading zeros.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_digits_unit
  import sidd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  sidd_operand_if.sink   operand,
  sidd_digit_if.source   digits
);

  // Pipeline registers: stage 0 holds the magnitude, stages 1..4 dabble.
  logic st_v [0:DD_STAGES];
  dd_t  st_d [0:DD_STAGES];
  logic take [0:DD_STAGES];

  // Digit count stage
  logic cnt_v;
  bcd_t cnt_bcd;
  pos_t cnt_count;
  logic take_cnt;

  // Output serializer
  logic ser_v;
  bcd_t ser_bcd;
  pos_t ser_count;
  pos_t ser_pos;
  logic ser_load;

  mag_t mag;

  // Magnitude of the request; the most negative value wraps to 2^31
  always_comb begin
    if (operand.value[VALUE_W-1]) begin
      mag = ~mag_t'(operand.value) + mag_t'(1);
    end else begin
      mag = mag_t'(operand.value);
    end
  end

  // Serializer loads when empty or when its last digit leaves
  assign ser_load = cnt_v && (!ser_v || (digits.ready && ser_pos == '0));
  assign take_cnt = !cnt_v || ser_load;

  // Stage load enables, back from the output
  always_comb begin
    take[DD_STAGES] = !st_v[DD_STAGES] || take_cnt;
    for (int i = DD_STAGES - 1; i >= 0; i--) begin
      take[i] = !st_v[i] || take[i+1];
    end
  end

  assign operand.ready = take[0];

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= DD_STAGES; i++) begin
        st_v[i] <= 1'b0;
      end
      cnt_v <= 1'b0;
    end else begin
      if (take[0]) begin
        st_v[0] <= operand.valid;
      end
      for (int i = 1; i <= DD_STAGES; i++) begin
        if (take[i]) begin
          st_v[i] <= st_v[i-1];
        end
      end
      if (take_cnt) begin
        cnt_v <= st_v[DD_STAGES];
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (take[0]) begin
      st_d[0] <= {{BCD_W{1'b0}}, mag};
    end
    for (int i = 1; i <= DD_STAGES; i++) begin
      if (take[i]) begin
        st_d[i] <= dd_steps(st_d[i-1]);
      end
    end
    if (take_cnt) begin
      cnt_bcd   <= st_d[DD_STAGES][DD_W-1:VALUE_W];
      cnt_count <= digit_count_of(st_d[DD_STAGES][DD_W-1:VALUE_W]);
    end
  end

  // Serializer: walks positions from the top digit down to zero
  always_ff @(posedge clk) begin
    if (rst) begin
      ser_v <= 1'b0;
    end else if (ser_load) begin
      ser_v <= 1'b1;
    end else if (ser_v && digits.ready && ser_pos == '0) begin
      ser_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_load) begin
      ser_bcd   <= cnt_bcd;
      ser_count <= cnt_count;
      ser_pos   <= cnt_count - pos_t'(1);
    end else if (ser_v && digits.ready && ser_pos != '0) begin
      ser_pos   <= ser_pos - pos_t'(1);
    end
  end

  // Result fields
  assign digits.valid       = ser_v;
  assign digits.digit       = digit_at(ser_bcd, ser_pos);
  assign digits.digit_count = ser_count;
  assign digits.last_digit  = (ser_pos == '0);

endmodule
`default_nettype wire

>>> rtl/sidd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sidd_checker
// Port-level checks on the digit results of the converter.
// ----------------------------------------------------------------------------
module sidd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [3:0] digit,
  input wire logic [3:0] digit_count,
  input wire logic       last_digit
);

  // A stalled result stays up
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Digits are decimal
  a_digit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> digit <= 4'd9)
    else $error("digit out of decimal range");

  // Digit count is 1 to 10
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (digit_count >= 4'd1 && digit_count <= 4'd10))
    else $error("digit count out of range");

  // A single-digit number is its own last digit
  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && digit_count == 4'd1 |-> last_digit)
    else $error("single digit not marked last");

  // Digits of one number follow without a gap and keep their count
  a_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_digit |=> out_valid && $stable(digit_count))
    else $error("digit run broken");

endmodule

bind signed_int_to_decimal_digits_unit sidd_checker u_sidd_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (digits.valid),
  .out_ready   (digits.ready),
  .digit       (digits.digit),
  .digit_count (digits.digit_count),
  .last_digit  (digits.last_digit)
);
`default_nettype wire

>>> bench/tb_signed_int_to_decimal_digits_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_digits_unit
// Self-checking bench for the signed integer to decimal digit converter.
// Integer requests go in through a queue-fed driver. A monitor checks each
// digit result against digits predicted from the request's magnitude. Both
// sides idle in random bursts, and the sender twice waits for a full drain.
// ----------------------------------------------------------------------------
module tb_signed_int_to_decimal_digits_unit;
  import sidd_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 6;
  localparam int RANDOM_ITEMS  = 250;
  localparam int QUIET_ITEMS   = 40;     // tail of the run with no idling
  localparam int TAIL_CYCLES   = 20;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_MAX    = 10;
  localparam longint MAG_MAX   = 64'd2147483648;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    bit                        drain_first;  // hold off until all digits are back
  } int_request_t;

  typedef struct packed {
    digit_t digit;
    pos_t   digit_count;
    logic   last_digit;
  } digit_result_t;

  logic clk;
  logic rst;

  sidd_operand_if operand_if ();
  sidd_digit_if   digit_if ();

  signed_int_to_decimal_digits_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .operand (operand_if),
    .digits  (digit_if)
  );

  int_request_t  request_queue [$];
  digit_result_t expected_digits [$];

  int          cycle_count = 0;
  int          requests_sent = 0;
  int          digits_checked = 0;
  int          mismatch_count = 0;
  int          src_gap_left = 0;
  int          sink_stall_left = 0;
  bit          timed_out = 0;
  bit [10:0]   lengths_seen = '0;

  // Clock and cycle counter
  always #CLK_HALF clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // No idling once only the last few requests remain
  function automatic bit in_final_stretch();
    return request_queue.size() <= QUIET_ITEMS;
  endfunction

  function automatic longint pow10(input int n);
    longint p;
    p = 1;
    for (int i = 0; i < n; i++) p = p * 10;
    return p;
  endfunction

  // Expected digits of one integer: magnitude, peeled least significant first
  function automatic void predict_digits(input logic signed [VALUE_W-1:0] value);
    mag_t          mag;
    digit_t        rev [DIGITS_MAX];
    int            count;
    digit_result_t res;
    mag = value;
    if (mag[VALUE_W-1]) mag = ~mag + 1'b1;
    count = 0;
    do begin
      rev[count] = digit_t'(mag % 10);
      mag = mag / 10;
      count++;
    end while (mag != 0 && count < DIGITS_MAX);
    for (int k = 0; k < count; k++) begin
      res.digit       = rev[count - 1 - k];
      res.digit_count = pos_t'(count);
      res.last_digit  = (k == count - 1);
      expected_digits = {expected_digits, res};
    end
    lengths_seen[count] = 1'b1;
  endfunction

  // Random integer: raw bits, a chosen digit length, or a power of ten plus -1, 0 or 1
  function automatic logic signed [VALUE_W-1:0] random_integer();
    int     mode;
    int     n;
    longint lo;
    longint hi;
    longint mag;
    mode = $urandom_range(0, 9);
    if (mode < 3) begin
      return $urandom();
    end
    if (mode < 8) begin
      n   = $urandom_range(1, DIGITS_MAX);
      lo  = (n == 1) ? 0 : pow10(n - 1);
      hi  = pow10(n) - 1;
      if (hi > MAG_MAX) hi = MAG_MAX;
      mag = lo + $urandom_range(0, 32'(hi - lo));
    end else begin
      n   = $urandom_range(0, DIGITS_MAX - 1);
      mag = pow10(n) + $urandom_range(0, 2) - 1;
    end
    if ($urandom_range(0, 1) == 1) mag = -mag;
    return mag[VALUE_W-1:0];
  endfunction

  // Request driver: holds a pending request until it is taken
  always @(posedge clk) begin : request_driver
    logic                      next_valid;
    logic signed [VALUE_W-1:0] next_value;
    if (rst) begin
      operand_if.valid <= 1'b0;
      operand_if.value <= '0;
      src_gap_left = 0;
    end else begin
      next_valid = 1'b0;
      next_value = operand_if.value;
      if (operand_if.valid && operand_if.ready) begin
        predict_digits(operand_if.value);
        void'(request_queue.pop_front());
        requests_sent++;
      end
      if (operand_if.valid && !operand_if.ready) begin
        next_valid = 1'b1;
      end else if (src_gap_left > 0) begin
        src_gap_left--;
      end else if (request_queue.size() != 0) begin
        if (request_queue[0].drain_first && expected_digits.size() != 0) begin
          // wait for the converter to empty out
        end else if (!in_final_stretch() && $urandom_range(0, 5) == 0) begin
          src_gap_left = $urandom_range(1, 13) - 1;
        end else begin
          next_valid = 1'b1;
          next_value = request_queue[0].value;
        end
      end
      operand_if.valid <= next_valid;
      operand_if.value <= next_value;
    end
  end

  // Digit monitor: compare against the oldest expected digit, stall at random
  always @(posedge clk) begin : digit_monitor
    digit_result_t want;
    if (rst) begin
      digit_if.ready <= 1'b0;
      sink_stall_left = 0;
    end else begin
      if (digit_if.valid && digit_if.ready) begin
        if (expected_digits.size() == 0) begin
          if (mismatch_count < REPORT_MAX)
            $display("[%0t] unexpected digit %0d count %0d last %0b", $realtime,
                     digit_if.digit, digit_if.digit_count, digit_if.last_digit);
          mismatch_count++;
        end else begin
          want = expected_digits.pop_front();
          digits_checked++;
          if (digit_if.digit !== want.digit ||
              digit_if.digit_count !== want.digit_count ||
              digit_if.last_digit !== want.last_digit) begin
            if (mismatch_count < REPORT_MAX)
              $display("[%0t] digit mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                       $realtime, want.digit, want.digit_count, want.last_digit,
                       digit_if.digit, digit_if.digit_count, digit_if.last_digit);
            mismatch_count++;
          end
        end
      end
      if (sink_stall_left > 0) begin
        sink_stall_left--;
        digit_if.ready <= 1'b0;
      end else if (!in_final_stretch() && $urandom_range(0, 6) == 0) begin
        sink_stall_left = $urandom_range(1, 13) - 1;
        digit_if.ready <= 1'b0;
      end else begin
        digit_if.ready <= 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int           directed [] = '{
      0, 1, -1, 9, -9, 10, -10, 99, 100, -1000, 7, 65536,
      32'sh7FFFFFFF, 32'sh80000000, 32'sh80000001,
      1000000000, -999999999, 32'sh55555555, 32'shAAAAAAAA,
      1234567890, -123456789, 4294967, -100000};
    int_request_t req;
    int           failures;

    clk = 1'b0;
    rst = 1'b1;
    operand_if.valid = 1'b0;
    operand_if.value = '0;
    digit_if.ready   = 1'b0;

    foreach (directed[i]) begin
      req.value       = directed[i];
      req.drain_first = 1'b0;
      request_queue   = {request_queue, req};
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      req.value       = random_integer();
      req.drain_first = (i == 0) || (i == RANDOM_ITEMS / 2);
      request_queue   = {request_queue, req};
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    fork
      begin
        while (request_queue.size() != 0 || operand_if.valid) @(posedge clk);
        while (expected_digits.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
      end
      begin
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
        timed_out = 1'b1;
      end
    join_any

    if (timed_out) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("CHECK FAILED");
    end else begin
      failures = mismatch_count + expected_digits.size();
      $display("Converted %0d integers into %0d checked digits, %0d of 10 lengths seen",
               requests_sent, digits_checked, $countones(lengths_seen));
      $display("Covered zero, both extremes, power-of-ten edges, random stalls, a full drain");
      if (failures == 0) begin
        $display("CHECK OK");
      end else begin
        $display("%0d mismatches, %0d digits never arrived", mismatch_count,
                 expected_digits.size());
        $display("CHECK FAILED");
      end
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/sidd_pkg.sv
rtl/sidd_if.sv
rtl/signed_int_to_decimal_digits_unit.sv
rtl/sidd_checker.sv
bench/tb_signed_int_to_decimal_digits_unit.sv
